// File: design/sle_pkg.sv
// Package for the stream latency and jitter estimator.
// Holds widths, codes, shared types and the fixed-point helper functions.
// Depends on nothing; every other design file imports it.
package sle_pkg;

   localparam int TIME_BITS   = 48;
   localparam int FRAC_BITS   = 8;
   localparam int OUT_W       = 32;
   localparam int EST_W       = OUT_W + FRAC_BITS;
   localparam int ALPHA_W     = 16;
   localparam int FACTOR_W    = 8;
   localparam int FACTOR_FRAC = 4;
   localparam int BUF_W       = 24;
   localparam int CSR_W       = BUF_W;
   localparam int CSR_IDX_W   = 2;
   localparam int FUNC_W      = 2;
   localparam int PROD_W      = EST_W + ALPHA_W;
   localparam int NET_W       = EST_W + FACTOR_W - FACTOR_FRAC;
   localparam int SUM_W       = NET_W + 1;
   localparam int STEP_W      = $clog2(ALPHA_W + 1);

   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(4096);
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(48);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [EST_W-1:0]     est_type;
   typedef logic [PROD_W-1:0]    prod_type;
   typedef logic [NET_W-1:0]     net_type;
   typedef logic [SUM_W-1:0]     sum_type;
   typedef logic [OUT_W-1:0]     out_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_PACKET = 2'd0,
      FN_DECODE = 2'd1,
      FN_RENDER = 2'd2,
      FN_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA  = 2'd0,
      CSR_FACTOR = 2'd1,
      CSR_BUFFER = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      SEL_AVG,
      SEL_JIT,
      SEL_DEC,
      SEL_REN
   } est_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_EW,
      S_MUL,
      S_JD,
      S_NET,
      S_NWAIT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [STEP_W-1:0]    steps;
      est_type              mcand;
      logic [ALPHA_W-1:0]   mult;
   } mul_cmd_type;

   typedef struct packed {
      logic     done;
      prod_type prod;
   } mul_rsp_type;

   typedef struct packed {
      est_type jit;
      est_type dec;
      est_type ren;
      net_type net;
      sum_type play;
   } est_set_type;

   // Microseconds to Q32.F, saturating at the largest estimate.
   function automatic est_type to_fixed(input time_type us);
      est_type r;
      if ((us >> OUT_W) != '0) begin
         r = '1;
      end else begin
         r = EST_W'(us[OUT_W-1:0]) << FRAC_BITS;
      end
      return r;
   endfunction

   // Q.F sum to integer microseconds, saturating at 32 bits.
   function automatic out_type sat_out(input sum_type fx);
      sum_type v;
      out_type r;
      v = fx >> FRAC_BITS;
      if (v > SUM_W'({OUT_W{1'b1}})) begin
         r = '1;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/sle_if.sv
// Channel interfaces of the stream latency and jitter estimator.
// One interface carries event words in, the other result words out.
// Depends on sle_pkg.
interface sle_req_if import sle_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [TIME_BITS-1:0] time_us;

   modport source (output valid, func, time_us, input ready);
   modport sink (input valid, func, time_us, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] jitter_us;
   logic [OUT_W-1:0] network_latency_us;
   logic [OUT_W-1:0] decode_latency_us;
   logic [OUT_W-1:0] render_latency_us;
   logic [OUT_W-1:0] playback_latency_us;
   logic [OUT_W-1:0] end_to_end_us;

   modport source (output valid, jitter_us, network_latency_us, decode_latency_us,
                   render_latency_us, playback_latency_us, end_to_end_us, input ready);
   modport sink (input valid, jitter_us, network_latency_us, decode_latency_us,
                 render_latency_us, playback_latency_us, end_to_end_us, output ready);
endinterface

// File: design/sle_serial_mul.sv
// Bit-serial shift-and-add multiplier of the estimator.
// The multiplier shifts out one bit per cycle, most significant first.
// Depends on sle_pkg.
module sle_serial_mul import sle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   prod_type           acc_ff, acc_in;
   est_type            mcand_ff, mcand_in;
   logic [ALPHA_W-1:0] mult_ff, mult_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         acc_in   = '0;
         mcand_in = cmd.mcand;
         mult_in  = cmd.mult;
         cnt_in   = cmd.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in  = (acc_ff << 1) + (mult_ff[ALPHA_W-1] ? PROD_W'(mcand_ff) : '0);
         mult_in = mult_ff << 1;
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// File: design/sle_result.sv
// Result register of the estimator: scales, saturates and holds one result word.
// The core may load a new word while the sink takes the previous one.
// Depends on sle_pkg and sle_if.
module sle_result import sle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  est_set_type est,
   output logic        free,
   sle_rsp_if.source   rsp_chan
);

   logic    valid_ff, valid_in;
   out_type jit_ff, net_ff, dec_ff, ren_ff, play_ff, e2e_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         jit_ff  <= sat_out(SUM_W'(est.jit));
         net_ff  <= sat_out(SUM_W'(est.net));
         dec_ff  <= sat_out(SUM_W'(est.dec));
         ren_ff  <= sat_out(SUM_W'(est.ren));
         play_ff <= sat_out(est.play);
         e2e_ff  <= sat_out(SUM_W'(est.net) + est.play);
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.jitter_us           = jit_ff;
   assign rsp_chan.network_latency_us  = net_ff;
   assign rsp_chan.decode_latency_us   = dec_ff;
   assign rsp_chan.render_latency_us   = ren_ff;
   assign rsp_chan.playback_latency_us = play_ff;
   assign rsp_chan.end_to_end_us       = e2e_ff;

endmodule

// File: design/stream_latency_jitter_estimator.sv
// Top level of the stream latency and jitter estimator.
// Holds the event sequencer, the estimates and the configuration registers.
// Depends on sle_pkg, sle_if, sle_serial_mul and sle_result.

// Events are taken one at a time and every event gives one result word. A later
// packet arrival updates the average and the jitter, a decoded or rendered frame its
// own estimate, and a clear, a first packet or an ignored frame none of them; an
// estimate that is still zero is seeded with the sample and skips the multiplier. The
// bit-serial multiplier retires one bit of alpha per cycle for each estimate update
// and one bit of the network factor per cycle for the network latency.
// The next event is taken as soon as its result is in the output register.
module stream_latency_jitter_estimator import sle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sle_req_if.sink               req_chan,
   sle_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   state_type          state_ff, state_in;

   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [BUF_W-1:0]    buffer_ff, buffer_in;
   time_type            last_arr_ff, last_arr_in;
   logic                arr_seen_ff, arr_seen_in;
   time_type            last_dec_ff, last_dec_in;
   logic                dec_seen_ff, dec_seen_in;
   est_type             avg_ff, avg_in;
   est_type             jit_ff, jit_in;
   est_type             dec_ff, dec_in;
   est_type             ren_ff, ren_in;

   func_type            func_ff, func_in;
   time_type            time_ff, time_in;
   est_sel_type         tgt_ff, tgt_in;
   est_type             x_ff, x_in;
   logic                up_ff, up_in;
   net_type             net_ff, net_in;
   sum_type             play_ff, play_in;

   mul_cmd_type mul_cmd;
   mul_rsp_type mul_rsp;
   est_set_type est_set;
   logic        rsp_free;
   logic        rsp_load;
   logic        req_take;

   time_type ref_time;
   time_type elapsed;
   logic     time_ge;
   logic     prep_ewma;
   est_type  e_sel;
   logic     est_zero;
   est_type  step;
   est_type  ewma_val;
   logic     est_we;
   est_type  est_val;

   assign req_take  = req_chan.valid && req_chan.ready;
   assign ref_time  = (func_ff == FN_RENDER) ? last_dec_ff : last_arr_ff;
   assign time_ge   = time_ff >= ref_time;
   assign elapsed   = time_ff - ref_time;
   assign prep_ewma = (func_ff == FN_PACKET && arr_seen_ff) ||
                      (func_ff == FN_DECODE && arr_seen_ff && time_ge) ||
                      (func_ff == FN_RENDER && dec_seen_ff && time_ge);

   always_comb begin
      case (tgt_ff)
         SEL_AVG: e_sel = avg_ff;
         SEL_JIT: e_sel = jit_ff;
         SEL_DEC: e_sel = dec_ff;
         default: e_sel = ren_ff;
      endcase
   end

   assign est_zero = (e_sel == '0);
   assign step     = mul_rsp.prod[PROD_W-1:ALPHA_W];
   assign ewma_val = up_ff ? (e_sel + step) : (e_sel - step);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_PREP;
         end
         S_PREP: begin
            state_in = prep_ewma ? S_EW : S_NET;
         end
         S_EW: begin
            if (est_zero) begin
               state_in = (tgt_ff == SEL_AVG) ? S_JD : S_NET;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_rsp.done) state_in = (tgt_ff == SEL_AVG) ? S_JD : S_NET;
         end
         S_JD: begin
            state_in = S_EW;
         end
         S_NET: begin
            state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (mul_rsp.done) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_load       = 1'b0;
      mul_cmd.start  = 1'b0;
      mul_cmd.steps  = STEP_W'(ALPHA_W);
      mul_cmd.mcand  = (x_ff >= e_sel) ? (x_ff - e_sel) : (e_sel - x_ff);
      mul_cmd.mult   = alpha_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
         end
         S_EW: begin
            mul_cmd.start = !est_zero;
         end
         S_NET: begin
            mul_cmd.start = 1'b1;
            mul_cmd.steps = STEP_W'(FACTOR_W);
            mul_cmd.mcand = jit_ff;
            mul_cmd.mult  = ALPHA_W'(factor_ff) << (ALPHA_W - FACTOR_W);
         end
         S_OUT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Datapath and estimate updates.
   always_comb begin
      alpha_in    = alpha_ff;
      factor_in   = factor_ff;
      buffer_in   = buffer_ff;
      last_arr_in = last_arr_ff;
      arr_seen_in = arr_seen_ff;
      last_dec_in = last_dec_ff;
      dec_seen_in = dec_seen_ff;
      avg_in      = avg_ff;
      jit_in      = jit_ff;
      dec_in      = dec_ff;
      ren_in      = ren_ff;
      func_in     = func_ff;
      time_in     = time_ff;
      tgt_in      = tgt_ff;
      x_in        = x_ff;
      up_in       = up_ff;
      net_in      = net_ff;
      play_in     = play_ff;
      est_we      = 1'b0;
      est_val     = x_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_in  = csr_wdata[ALPHA_W-1:0];
            CSR_FACTOR: factor_in = csr_wdata[FACTOR_W-1:0];
            CSR_BUFFER: buffer_in = csr_wdata[BUF_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in = func_type'(req_chan.func);
               time_in = req_chan.time_us;
            end
         end
         S_PREP: begin
            x_in = to_fixed(elapsed);
            case (func_ff)
               FN_PACKET: begin
                  arr_seen_in = 1'b1;
                  last_arr_in = time_ff;
                  tgt_in      = SEL_AVG;
                  if (!time_ge) x_in = '0;
               end
               FN_DECODE: begin
                  last_dec_in = time_ff;
                  dec_seen_in = 1'b1;
                  tgt_in      = SEL_DEC;
               end
               FN_RENDER: begin
                  tgt_in = SEL_REN;
               end
               default: begin
                  last_arr_in = '0;
                  arr_seen_in = 1'b0;
                  last_dec_in = '0;
                  dec_seen_in = 1'b0;
                  avg_in      = '0;
                  jit_in      = '0;
                  dec_in      = '0;
                  ren_in      = '0;
                  buffer_in   = '0;
               end
            endcase
         end
         S_EW: begin
            up_in = x_ff >= e_sel;
            if (est_zero) begin
               est_we  = 1'b1;
               est_val = x_ff;
            end
         end
         S_MUL: begin
            if (mul_rsp.done) begin
               est_we  = 1'b1;
               est_val = ewma_val;
            end
         end
         S_JD: begin
            x_in   = (x_ff >= avg_ff) ? (x_ff - avg_ff) : (avg_ff - x_ff);
            tgt_in = SEL_JIT;
         end
         S_NET: begin
            play_in = (SUM_W'(buffer_ff) << FRAC_BITS) + SUM_W'(dec_ff) + SUM_W'(ren_ff);
         end
         S_NWAIT: begin
            if (mul_rsp.done) net_in = mul_rsp.prod[NET_W+FACTOR_FRAC-1:FACTOR_FRAC];
         end
         default: begin
         end
      endcase

      if (est_we) begin
         case (tgt_ff)
            SEL_AVG: avg_in = est_val;
            SEL_JIT: jit_in = est_val;
            SEL_DEC: dec_in = est_val;
            default: ren_in = est_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         alpha_ff    <= ALPHA_RESET;
         factor_ff   <= FACTOR_RESET;
         buffer_ff   <= '0;
         last_arr_ff <= '0;
         arr_seen_ff <= 1'b0;
         last_dec_ff <= '0;
         dec_seen_ff <= 1'b0;
         avg_ff      <= '0;
         jit_ff      <= '0;
         dec_ff      <= '0;
         ren_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         alpha_ff    <= alpha_in;
         factor_ff   <= factor_in;
         buffer_ff   <= buffer_in;
         last_arr_ff <= last_arr_in;
         arr_seen_ff <= arr_seen_in;
         last_dec_ff <= last_dec_in;
         dec_seen_ff <= dec_seen_in;
         avg_ff      <= avg_in;
         jit_ff      <= jit_in;
         dec_ff      <= dec_in;
         ren_ff      <= ren_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      time_ff <= time_in;
      tgt_ff  <= tgt_in;
      x_ff    <= x_in;
      up_ff   <= up_in;
      net_ff  <= net_in;
      play_ff <= play_in;
   end

   assign est_set.jit  = jit_ff;
   assign est_set.dec  = dec_ff;
   assign est_set.ren  = ren_ff;
   assign est_set.net  = net_ff;
   assign est_set.play = play_ff;

   sle_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .rsp   (mul_rsp)
   );

   sle_result u_result (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .est      (est_set),
      .free     (rsp_free),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_take_to_prep: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_PREP)
      else $error("accepted word did not enter preparation");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_MUL || state_ff == S_NWAIT))
      else $error("multiplier finished with no step waiting for it");

   a_arrival_ref: assert property (@(posedge clock) disable iff (reset)
      !arr_seen_ff |-> (last_arr_ff == '0 && dec_ff == '0 && avg_ff == '0))
      else $error("arrival state set before any arrival");

   a_decode_ref: assert property (@(posedge clock) disable iff (reset)
      !dec_seen_ff |-> (last_dec_ff == '0 && ren_ff == '0))
      else $error("render estimate moved before any decode");
`endif

endmodule
